// ===== src/array_set_operation_engine_core_assert.svh =====
// Assertion macros used by the checker file of the set operation engine.
`ifndef ARRAY_SET_OPERATION_ENGINE_CORE_ASSERT_SVH
`define ARRAY_SET_OPERATION_ENGINE_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define ASOP_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asop check failed");

// Condition must hold in the cycle after the trigger.
`define ASOP_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asop check failed");

`endif

// ===== src/asop_pkg.sv =====
// Shared types, constants and codes of the set operation engine.
package asop_pkg;

  localparam int MAX_ELEMS = 16;
  localparam int RES_LIMIT = 32;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ELEMS);
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int RES_W     = $clog2(RES_LIMIT + 1);

  // Item actions.
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  // Operation register codes.
  localparam logic [1:0] OP_INTERSECT = 2'd0;
  localparam logic [1:0] OP_UNION     = 2'd1;
  localparam logic [1:0] OP_A_MINUS_B = 2'd2;
  localparam logic [1:0] OP_B_MINUS_A = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_LOAD,
    S_REF,
    S_CMP,
    S_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic run_start;
    logic next_phase;
    logic load_cur;
    logic clr_j;
    logic inc_j;
    logic inc_i;
    logic keep;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic src_done;
    logic ref_empty;
    logic ref_last;
    logic match;
    logic want;
    logic two_phase;
    logic n_pre_last;
  } status_t;

endpackage

// ===== src/asop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module asop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/asop_ctrl.sv =====
// Controller state machine that sequences loads, scans and result flushes.
module asop_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       action,
  input  asop_pkg::status_t stat,
  output asop_pkg::cmd_t   cmd,
  output logic             busy
);

  asop_pkg::state_t state;
  asop_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asop_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != asop_pkg::S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      asop_pkg::S_IDLE: begin
        if (start) begin
          case (action)
            asop_pkg::ACT_LOAD_A: cmd.load_a = 1'b1;
            asop_pkg::ACT_LOAD_B: cmd.load_b = 1'b1;
            asop_pkg::ACT_RUN: begin
              cmd.run_start = 1'b1;
              state_next    = asop_pkg::S_SRC;
            end
            default: ;
          endcase
        end
      end
      asop_pkg::S_SRC: begin
        // The source read address is presented in this state.
        if (stat.src_done) begin
          if (stat.two_phase) begin
            cmd.next_phase = 1'b1;
          end else begin
            state_next = asop_pkg::S_FLUSH;
          end
        end else begin
          state_next = asop_pkg::S_LOAD;
        end
      end
      asop_pkg::S_LOAD: begin
        cmd.load_cur = 1'b1;
        cmd.clr_j    = 1'b1;
        state_next   = asop_pkg::S_REF;
      end
      asop_pkg::S_REF: begin
        if (stat.ref_empty) begin
          // Nothing to search: the element is not present.
          cmd.keep = !stat.want;
          if (cmd.keep && stat.n_pre_last) begin
            state_next = asop_pkg::S_FLUSH;
          end else begin
            cmd.inc_i  = 1'b1;
            state_next = asop_pkg::S_SRC;
          end
        end else begin
          state_next = asop_pkg::S_CMP;
        end
      end
      asop_pkg::S_CMP: begin
        if (stat.match || stat.ref_last) begin
          // Search ends on the first hit or on the last reference element.
          cmd.keep = stat.match ? stat.want : !stat.want;
          if (cmd.keep && stat.n_pre_last) begin
            state_next = asop_pkg::S_FLUSH;
          end else begin
            cmd.inc_i  = 1'b1;
            state_next = asop_pkg::S_SRC;
          end
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = asop_pkg::S_REF;
        end
      end
      asop_pkg::S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = asop_pkg::S_IDLE;
      end
      default: begin
        state_next = asop_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/asop_datapath.sv =====
// Datapath: list memories, counters, compare unit and result registers.
module asop_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  asop_pkg::cmd_t               cmd,
  output asop_pkg::status_t            stat,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_data,
  input  logic signed [asop_pkg::DATA_W-1:0] value,
  output logic                         res_strobe,
  output logic signed [asop_pkg::DATA_W-1:0] value_res,
  output logic                         is_last,
  output logic                         is_empty,
  output logic                         overflowed
);

  logic [1:0]                   operation;
  logic                         phase;
  logic                         overflow;
  logic [asop_pkg::CNT_W-1:0]   cnt_a;
  logic [asop_pkg::CNT_W-1:0]   cnt_b;
  logic [asop_pkg::CNT_W-1:0]   idx_i;
  logic [asop_pkg::ADDR_W-1:0]  idx_j;
  logic [asop_pkg::RES_W-1:0]   n_found;
  logic [asop_pkg::DATA_W-1:0]  cur;
  logic [asop_pkg::DATA_W-1:0]  pend;
  logic                         pend_valid;

  logic                         src_is_b;
  logic [asop_pkg::CNT_W-1:0]   src_cnt;
  logic [asop_pkg::CNT_W-1:0]   ref_cnt;
  logic                         we_a;
  logic                         we_b;
  logic [asop_pkg::ADDR_W-1:0]  raddr_a;
  logic [asop_pkg::ADDR_W-1:0]  raddr_b;
  logic [asop_pkg::DATA_W-1:0]  rdata_a;
  logic [asop_pkg::DATA_W-1:0]  rdata_b;
  logic [asop_pkg::DATA_W-1:0]  src_data;
  logic [asop_pkg::DATA_W-1:0]  ref_data;

  // Source and reference roles follow the operation and the union phase.
  always_comb begin
    src_is_b = (operation == asop_pkg::OP_B_MINUS_A) ||
               ((operation == asop_pkg::OP_UNION) && phase);
    src_cnt  = src_is_b ? cnt_b : cnt_a;
    if ((operation == asop_pkg::OP_UNION) && !phase) begin
      ref_cnt = '0;
    end else begin
      ref_cnt = src_is_b ? cnt_a : cnt_b;
    end
  end

  // Memory ports: appends write at the fill count, scans read at i and j.
  assign we_a     = cmd.load_a && (cnt_a < asop_pkg::CNT_W'(asop_pkg::MAX_ELEMS));
  assign we_b     = cmd.load_b && (cnt_b < asop_pkg::CNT_W'(asop_pkg::MAX_ELEMS));
  assign raddr_a  = src_is_b ? idx_j : idx_i[asop_pkg::ADDR_W-1:0];
  assign raddr_b  = src_is_b ? idx_i[asop_pkg::ADDR_W-1:0] : idx_j;
  assign src_data = src_is_b ? rdata_b : rdata_a;
  assign ref_data = src_is_b ? rdata_a : rdata_b;

  asop_ram #(
    .WIDTH (asop_pkg::DATA_W),
    .DEPTH (asop_pkg::MAX_ELEMS)
  ) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[asop_pkg::ADDR_W-1:0]),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  asop_ram #(
    .WIDTH (asop_pkg::DATA_W),
    .DEPTH (asop_pkg::MAX_ELEMS)
  ) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[asop_pkg::ADDR_W-1:0]),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Status back to the controller.
  always_comb begin
    stat.src_done   = (idx_i == src_cnt);
    stat.ref_empty  = (ref_cnt == '0);
    stat.ref_last   = ((asop_pkg::CNT_W'(idx_j) + asop_pkg::CNT_W'(1)) == ref_cnt);
    stat.match      = (ref_data == cur);
    stat.want       = (operation == asop_pkg::OP_INTERSECT);
    stat.two_phase  = (operation == asop_pkg::OP_UNION) && !phase;
    stat.n_pre_last = (n_found == asop_pkg::RES_W'(asop_pkg::RES_LIMIT - 1));
  end

  // Operation register.
  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= asop_pkg::OP_INTERSECT;
    end else if (cfg_write) begin
      operation <= cfg_data;
    end
  end

  // List fill counts and the overflow flag; a flush empties both lists.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      overflow <= 1'b0;
    end else if (cmd.flush) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      overflow <= 1'b0;
    end else begin
      if (cmd.load_a) begin
        if (we_a) begin
          cnt_a <= cnt_a + asop_pkg::CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.load_b) begin
        if (we_b) begin
          cnt_b <= cnt_b + asop_pkg::CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  // Scan counters and union phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i <= '0;
      idx_j <= '0;
      phase <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        idx_i <= '0;
        phase <= 1'b0;
      end else if (cmd.next_phase) begin
        idx_i <= '0;
        phase <= 1'b1;
      end else if (cmd.inc_i) begin
        idx_i <= idx_i + asop_pkg::CNT_W'(1);
      end
      if (cmd.clr_j) begin
        idx_j <= '0;
      end else if (cmd.inc_j) begin
        idx_j <= idx_j + asop_pkg::ADDR_W'(1);
      end
    end
  end

  // Current source element under test.
  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur <= src_data;
    end
  end

  // One result is held back so the final one can be marked last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      n_found    <= '0;
    end else if (cmd.run_start || cmd.flush) begin
      pend_valid <= 1'b0;
      n_found    <= '0;
    end else if (cmd.keep) begin
      pend_valid <= 1'b1;
      n_found    <= n_found + asop_pkg::RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.keep) begin
      pend <= cur;
    end
  end

  // Result registers: release the held result, or the final or empty item.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= cmd.flush || (cmd.keep && pend_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush || (cmd.keep && pend_valid)) begin
      value_res  <= pend_valid ? pend : '0;
      is_last    <= cmd.flush;
      is_empty   <= cmd.flush && !pend_valid;
      overflowed <= overflow;
    end
  end

endmodule

// ===== src/array_set_operation_engine_core.sv =====
// Top level of the set operation engine: controller plus datapath.
//
//   Channel   Handshake                  Payload
//   input     start, busy                action, value
//   result    res_strobe (one cycle)     value_res, is_last, is_empty, overflowed
//   config    cfg_write                  cfg_data (operation)
//
// An append item leaves busy low.
// A run scans each source element against the reference list; in a union
// every A element is checked against an empty list, and a second phase then
// scans list B against list A. Each compare goes through the single compare
// unit, fed by the registered read of the list memories.
// Reset clears the fill counts, the flags and the operation; no clearing pass.
// Results cannot be stalled: each one shows for exactly one cycle.
module array_set_operation_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic signed [asop_pkg::DATA_W-1:0]  value,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_data,
  output logic                                res_strobe,
  output logic signed [asop_pkg::DATA_W-1:0]  value_res,
  output logic                                is_last,
  output logic                                is_empty,
  output logic                                overflowed
);

  asop_pkg::cmd_t    cmd;
  asop_pkg::status_t stat;

  // Sequencing of loads and runs.
  asop_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Storage, compare and result registers.
  asop_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .value      (value),
    .res_strobe (res_strobe),
    .value_res  (value_res),
    .is_last    (is_last),
    .is_empty   (is_empty),
    .overflowed (overflowed)
  );

endmodule

// ===== src/asop_checker.sv =====
// Port-level checker of the set operation engine and its bind.
`include "array_set_operation_engine_core_assert.svh"

module asop_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   action,
  input logic                         res_strobe,
  input logic [asop_pkg::DATA_W-1:0]  value_res,
  input logic                         is_last,
  input logic                         is_empty
);

  // An empty result is a single zero item that closes the run.
  `ASOP_CHECK_NOW(empty_is_final, res_strobe && is_empty, is_last && (value_res == '0))

  // A run item makes the block busy.
  `ASOP_CHECK_NEXT(run_goes_busy, start && !busy && (action == asop_pkg::ACT_RUN), busy)

  // Items before the last one are only delivered while the run is in progress.
  `ASOP_CHECK_NOW(middle_while_busy, res_strobe && !is_last, busy)

  // Nothing follows the last item of a run in the next cycle.
  `ASOP_CHECK_NEXT(quiet_after_last, res_strobe && is_last, !res_strobe)

endmodule

bind array_set_operation_engine_core asop_checker u_asop_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .action     (action),
  .res_strobe (res_strobe),
  .value_res  (value_res),
  .is_last    (is_last),
  .is_empty   (is_empty)
);

// ===== tb/tb_array_set_operation_engine_core.sv =====
// Self-checking testbench for the set operation engine core.
`timescale 1ns / 100ps

module tb_array_set_operation_engine_core;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [asop_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [asop_pkg::DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam int TARGET_ITEMS = 430;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1_500_000;

  // One result item as the block should emit it.
  typedef struct packed {
    logic [asop_pkg::DATA_W-1:0] elem;
    logic                        last_flag;
    logic                        empty_flag;
    logic                        ovf_flag;
  } set_result_t;

  // Tracks both lists and the operation, and holds the results still due.
  class set_op_scoreboard;
    logic [asop_pkg::DATA_W-1:0] list_a [asop_pkg::MAX_ELEMS];
    logic [asop_pkg::DATA_W-1:0] list_b [asop_pkg::MAX_ELEMS];
    int                          count_a;
    int                          count_b;
    bit                          dropped;
    logic [1:0]                  operation;
    set_result_t                 due_results [$];
    int                          errors;

    function new();
      count_a = 0;
      count_b = 0;
      dropped = 0;
      operation = asop_pkg::OP_INTERSECT;
      errors = 0;
    endfunction

    function void set_operation(logic [1:0] op);
      operation = op;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Returns whether v occurs in list B (in_b set) or list A.
    function bit in_list(bit in_b, logic [asop_pkg::DATA_W-1:0] v);
      if (in_b) begin
        for (int i = 0; i < count_b; i++) if (list_b[i] == v) return 1;
      end else begin
        for (int i = 0; i < count_a; i++) if (list_a[i] == v) return 1;
      end
      return 0;
    endfunction

    // Builds the result list of a run and queues it, then clears both lists.
    function void run_set_operation();
      logic [asop_pkg::DATA_W-1:0] elems [$];
      int                          n;
      set_result_t                 r;
      case (operation)
        asop_pkg::OP_INTERSECT: begin
          for (int i = 0; i < count_a; i++)
            if (in_list(1, list_a[i])) elems.push_back(list_a[i]);
        end
        asop_pkg::OP_UNION: begin
          for (int i = 0; i < count_a; i++) elems.push_back(list_a[i]);
          for (int j = 0; j < count_b; j++)
            if (!in_list(0, list_b[j])) elems.push_back(list_b[j]);
        end
        asop_pkg::OP_A_MINUS_B: begin
          for (int i = 0; i < count_a; i++)
            if (!in_list(1, list_a[i])) elems.push_back(list_a[i]);
        end
        default: begin
          for (int j = 0; j < count_b; j++)
            if (!in_list(0, list_b[j])) elems.push_back(list_b[j]);
        end
      endcase
      n = (elems.size() > asop_pkg::RES_LIMIT) ? asop_pkg::RES_LIMIT : elems.size();
      if (n == 0) begin
        r = '{elem: '0, last_flag: 1'b1, empty_flag: 1'b1, ovf_flag: dropped};
        due_results.push_back(r);
      end else begin
        for (int k = 0; k < n; k++) begin
          r = '{elem: elems[k], last_flag: (k == n - 1), empty_flag: 1'b0,
                ovf_flag: dropped};
          due_results.push_back(r);
        end
      end
      count_a = 0;
      count_b = 0;
      dropped = 0;
    endfunction

    // Called for every accepted input item.
    function void note_item(logic [1:0] act, logic [asop_pkg::DATA_W-1:0] v);
      case (act)
        asop_pkg::ACT_LOAD_A: begin
          if (count_a < asop_pkg::MAX_ELEMS) begin
            list_a[count_a] = v;
            count_a++;
          end else begin
            dropped = 1;
          end
        end
        asop_pkg::ACT_LOAD_B: begin
          if (count_b < asop_pkg::MAX_ELEMS) begin
            list_b[count_b] = v;
            count_b++;
          end else begin
            dropped = 1;
          end
        end
        asop_pkg::ACT_RUN: run_set_operation();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [asop_pkg::DATA_W-1:0] want,
                                logic [asop_pkg::DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    // Called for every result item the block emits.
    function void check_result(logic [asop_pkg::DATA_W-1:0] v, logic l, logic e,
                               logic o);
      set_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result item: value_res %0d, is_last %0b, is_empty %0b",
               $signed(v), l, e);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("value_res", want.elem, v);
      compare_field("is_last", {31'b0, want.last_flag}, {31'b0, l});
      compare_field("is_empty", {31'b0, want.empty_flag}, {31'b0, e});
      compare_field("overflowed", {31'b0, want.ovf_flag}, {31'b0, o});
    endfunction
  endclass

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic                               busy;
  logic [1:0]                         action = asop_pkg::ACT_LOAD_A;
  logic signed [asop_pkg::DATA_W-1:0] value = '0;
  logic                               cfg_write = 1'b0;
  logic [1:0]                         cfg_data = asop_pkg::OP_INTERSECT;
  logic                               res_strobe;
  logic signed [asop_pkg::DATA_W-1:0] value_res;
  logic                               is_last;
  logic                               is_empty;
  logic                               overflowed;

  set_op_scoreboard            sb = new();
  int                          items_sent = 0;
  int                          cycle_count = 0;
  bit                          no_gaps = 0;
  logic [asop_pkg::DATA_W-1:0] val_pool [4];

  array_set_operation_engine_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .value      (value),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .res_strobe (res_strobe),
    .value_res  (value_res),
    .is_last    (is_last),
    .is_empty   (is_empty),
    .overflowed (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked as it shows.
  always @(posedge clk) begin
    if (!rst && res_strobe) sb.check_result(value_res, is_last, is_empty, overflowed);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one item, waits for it to be taken, then idles for a random gap.
  // Start stays high when no gap follows, so back-to-back items are seen.
  task automatic send_item(logic [1:0] act, logic [asop_pkg::DATA_W-1:0] v);
    int gap;
    start <= 1'b1;
    action <= act;
    value <= v;
    do @(posedge clk); while (busy);
    sb.note_item(act, v);
    if (act != ACT_UNUSED) items_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every due result has come and the block is idle.
  task automatic wait_for_results();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the operation register; only called while the block is idle.
  task automatic write_operation(logic [1:0] op);
    cfg_write <= 1'b1;
    cfg_data <= op;
    @(posedge clk);
    sb.set_operation(op);
    cfg_write <= 1'b0;
  endtask

  // Half the values from a small pool, so lists share elements and hold duplicates.
  function automatic logic [asop_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return $urandom;
      default: return val_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  // Mostly short lists, sometimes long enough to overflow.
  function automatic int draw_count();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(10, 19) : $urandom_range(0, 6);
  endfunction

  initial begin
    int          na;
    int          nb;
    int          ia;
    int          ib;
    int          phase;
    int          sets;
    logic [1:0]  op;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: intersection at its reset value, with extremes and duplicates.
    send_item(asop_pkg::ACT_LOAD_A, VAL_MIN);
    send_item(asop_pkg::ACT_LOAD_A, VAL_MAX);
    send_item(asop_pkg::ACT_LOAD_A, '1);
    send_item(asop_pkg::ACT_LOAD_A, '1);
    send_item(asop_pkg::ACT_LOAD_B, '1);
    send_item(asop_pkg::ACT_LOAD_B, VAL_MIN);
    send_item(asop_pkg::ACT_LOAD_B, 32'd5);
    send_item(ACT_UNUSED, $urandom);
    send_item(asop_pkg::ACT_RUN, $urandom);
    // A run on empty lists gives the single empty item.
    send_item(asop_pkg::ACT_RUN, $urandom);
    wait_for_results();

    // Union keeps duplicates from both lists.
    write_operation(asop_pkg::OP_UNION);
    send_item(asop_pkg::ACT_LOAD_A, 32'd3);
    send_item(asop_pkg::ACT_LOAD_A, 32'd3);
    send_item(asop_pkg::ACT_LOAD_B, 32'd3);
    send_item(asop_pkg::ACT_LOAD_B, 32'd7);
    send_item(asop_pkg::ACT_LOAD_B, 32'd7);
    send_item(asop_pkg::ACT_RUN, '1);
    wait_for_results();

    write_operation(asop_pkg::OP_A_MINUS_B);
    send_item(asop_pkg::ACT_LOAD_A, 32'd0);
    send_item(asop_pkg::ACT_LOAD_A, 32'd1);
    send_item(asop_pkg::ACT_LOAD_B, 32'd1);
    send_item(asop_pkg::ACT_RUN, '0);
    wait_for_results();

    // B minus A where B is covered by A: an empty result.
    write_operation(asop_pkg::OP_B_MINUS_A);
    send_item(asop_pkg::ACT_LOAD_B, VAL_MAX);
    send_item(asop_pkg::ACT_LOAD_A, VAL_MAX);
    send_item(asop_pkg::ACT_RUN, $urandom);

    // Random part: phases of one operation, each with one to four load-and-run sets.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      op = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
      phase++;
      wait_for_results();
      write_operation(op);
      no_gaps = ($urandom_range(0, 3) == 0);
      sets = $urandom_range(1, 4);
      for (int s = 0; s < sets; s++) begin
        for (int p = 0; p < 4; p++) val_pool[p] = $urandom;
        if ($urandom_range(0, 1) == 0) val_pool[0] = '0;
        na = draw_count();
        nb = draw_count();
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
          if ($urandom_range(0, 11) == 0) send_item(ACT_UNUSED, $urandom);
          if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
            send_item(asop_pkg::ACT_LOAD_A, pick_value());
            ia++;
          end else begin
            send_item(asop_pkg::ACT_LOAD_B, pick_value());
            ib++;
          end
        end
        // Now and then let the block drain completely before the run.
        if ($urandom_range(0, 4) == 0) wait_for_results();
        send_item(asop_pkg::ACT_RUN, $urandom);
      end
    end

    wait_for_results();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
